// ===== hw/rtl/ram_expansion_dma_controller_core_assert.svh =====
// Assertion macros for the RAM expansion DMA controller.
`ifndef RAM_EXPANSION_DMA_CONTROLLER_CORE_ASSERT_SVH
`define RAM_EXPANSION_DMA_CONTROLLER_CORE_ASSERT_SVH
`ifndef SYNTH
`define REU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("reu assertion failed");
`define REU_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("reu forbidden condition");
`else
`define REU_ASSERT(lbl, clk, rst_n, prop)
`define REU_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ===== hw/rtl/reu_pkg.sv =====
// Shared types and constants of the RAM expansion DMA controller.
`timescale 1ns / 1ps
package reu_pkg;
	localparam int RAM_ADDRESS_BITS = 20;
	localparam int RAM_DEPTH = 1 << RAM_ADDRESS_BITS;

	localparam logic [1:0] CMD_READ  = 2'd0;
	localparam logic [1:0] CMD_WRITE = 2'd1;
	localparam logic [1:0] CMD_DMA   = 2'd2;

	localparam logic [4:0] REG_STATUS  = 5'd0;
	localparam logic [4:0] REG_COMMAND = 5'd1;
	localparam logic [4:0] REG_HOST_LO = 5'd2;
	localparam logic [4:0] REG_HOST_HI = 5'd3;
	localparam logic [4:0] REG_EXP_LO  = 5'd4;
	localparam logic [4:0] REG_EXP_MID = 5'd5;
	localparam logic [4:0] REG_EXP_HI  = 5'd6;
	localparam logic [4:0] REG_LEN_LO  = 5'd7;
	localparam logic [4:0] REG_LEN_HI  = 5'd8;
	localparam logic [4:0] REG_IMASK   = 5'd9;
	localparam logic [4:0] REG_ADDRCTL = 5'd10;

	localparam logic [15:0] TRIGGER_ADDR = 16'hff00;

	typedef enum logic [2:0] {
		PH_IDLE, PH_STASH, PH_FETCH, PH_SWAP_A, PH_SWAP_B, PH_VERIFY, PH_VERR
	} phase_t;

	typedef enum logic [2:0] {
		K_PLAIN, K_FETCH, K_SWAP_A, K_SWAP_B, K_VERIFY, K_VERR
	} kind_t;

	function automatic phase_t first_phase(input logic [1:0] t);
		phase_t p;
		case (t)
			2'd0: p = PH_STASH;
			2'd1: p = PH_FETCH;
			2'd2: p = PH_SWAP_A;
			default: p = PH_VERIFY;
		endcase
		return p;
	endfunction
endpackage

// ===== hw/rtl/ram_expansion_dma_controller_core.sv =====
// RAM expansion DMA controller: register window, transfer engine, expansion RAM.
// Each transfer is registered into stage 1 and then into the output register.
// Throughput: one item per cycle while the output is not stalled; a verify-phase DMA
// cycle holds off the next item, since the RAM read of that byte decides the next phase.
// Reset (arst_n low) sets the architectural registers and shadows to their power-up values at once;
// the expansion RAM and swap byte keep their contents and need no clearing pass.
`timescale 1ns / 1ps
`include "ram_expansion_dma_controller_core_assert.svh"
module ram_expansion_dma_controller_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic        io2_select,
	input  logic [15:0] bus_address,
	input  logic [7:0]  write_data,
	input  logic [7:0]  host_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  read_data,
	output logic        read_claimed,
	output logic        dma_hold,
	output logic        irq_active,
	output logic [15:0] dma_address,
	output logic        dma_write,
	output logic [7:0]  dma_write_data
);
	import reu_pkg::*;

	localparam int RAB = RAM_ADDRESS_BITS;

	// architectural registers
	logic        size_flag_q;
	logic [7:0]  status_q, cmd_q, imask_q, addrctl_q;
	logic [15:0] host_q, len_q;
	logic [23:0] exp_q;
	logic        autoload_q;
	phase_t      phase_q;
	// shadow copies (only the bytes that autoload restores)
	logic [7:0]  sh_cmd_q, sh_hlo_q, sh_hhi_q, sh_elo_q, sh_emid_q, sh_ehi_q;
	logic [7:0]  sh_llo_q, sh_lhi_q;
	logic [7:0]  swap_q;

	// expansion RAM
	logic [7:0]     mem [RAM_DEPTH];
	logic [7:0]     ram_rd_q;
	logic           ram_we, ram_re;
	logic [RAB-1:0] ram_addr;

	// stage 1: RAM read in flight
	logic        v_s1;
	kind_t       kind_s1;
	logic [7:0]  rdata_s1, hb_s1;
	logic        claim_s1, dwr_s1, last_s1;
	logic [15:0] daddr_s1;

	logic accept, adv_s1, lock_s1, s2_apply;

	assign lock_s1  = v_s1 && (kind_s1 == K_VERIFY || kind_s1 == K_VERR);
	assign adv_s1   = v_s1 && (!out_valid || !out_stall);
	assign in_stall = (v_s1 && !adv_s1) || lock_s1;
	assign accept   = in_valid && !in_stall;
	assign s2_apply = adv_s1 && lock_s1;

	// next-state logic
	logic [7:0]  n_status, n_cmd, n_imask, n_addrctl, fl;
	logic [15:0] n_host, n_len;
	logic [23:0] n_exp;
	logic        n_autoload, fin, active, ne;
	phase_t      n_phase;
	logic [4:0]  idx;
	logic [7:0]  rv;
	kind_t       kind_d;
	logic        claim_d, dwr_d;
	logic [7:0]  rdata_d;

	assign active = (phase_q != PH_IDLE);
	assign idx    = bus_address[4:0];
	assign ne     = (ram_rd_q != hb_s1);

	// register read mux with fixed masks
	always_comb begin
		case (idx)
			REG_STATUS:  rv = status_q | {3'b000, size_flag_q, 4'h0};
			REG_COMMAND: rv = cmd_q;
			REG_HOST_LO: rv = host_q[7:0];
			REG_HOST_HI: rv = host_q[15:8];
			REG_EXP_LO:  rv = exp_q[7:0];
			REG_EXP_MID: rv = exp_q[15:8];
			REG_EXP_HI:  rv = exp_q[23:16] | 8'hf8;
			REG_LEN_LO:  rv = len_q[7:0];
			REG_LEN_HI:  rv = len_q[15:8];
			REG_IMASK:   rv = imask_q | 8'h1f;
			REG_ADDRCTL: rv = addrctl_q | 8'h3f;
			default:     rv = 8'hff;
		endcase
	end

	always_comb begin
		n_status   = status_q;
		n_cmd      = cmd_q;
		n_imask    = imask_q;
		n_addrctl  = addrctl_q;
		n_host     = host_q;
		n_len      = len_q;
		n_exp      = exp_q;
		n_autoload = autoload_q;
		n_phase    = phase_q;
		fin        = 1'b0;
		fl         = 8'h00;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_addr   = exp_q[RAB-1:0];
		kind_d     = K_PLAIN;
		claim_d    = 1'b0;
		dwr_d      = 1'b0;
		rdata_d    = 8'h00;
		if (s2_apply) begin
			// verify outcome, now that the RAM byte is back
			if (kind_s1 == K_VERR) begin
				fin = 1'b1;
				fl  = 8'h20 | ((!ne && last_s1) ? 8'h40 : 8'h00);
			end else if (last_s1) begin
				fin = 1'b1;
				fl  = 8'h40 | (ne ? 8'h20 : 8'h00);
			end else if (ne) begin
				n_phase = PH_VERR;
			end
		end else if (accept) begin
			case (command)
				CMD_READ: begin
					if (!active && io2_select) begin
						rdata_d = rv;
						claim_d = 1'b1;
						if (idx == REG_STATUS)
							n_status = 8'h00;
					end
				end
				CMD_WRITE: begin
					if (!active && io2_select) begin
						case (idx)
							REG_STATUS: ;
							REG_COMMAND: begin
								n_cmd      = write_data;
								n_autoload = write_data[5];
								if (write_data[7] && write_data[4])
									n_phase = first_phase(write_data[1:0]);
							end
							REG_HOST_LO: n_host = {sh_hhi_q, write_data};
							REG_HOST_HI: n_host = {write_data, sh_hlo_q};
							REG_EXP_LO:  n_exp = {exp_q[23:16], sh_emid_q, write_data};
							REG_EXP_MID: n_exp = {exp_q[23:16], write_data, sh_elo_q};
							REG_EXP_HI:  n_exp = {write_data, exp_q[15:0]};
							REG_LEN_LO:  n_len = {sh_lhi_q, write_data};
							REG_LEN_HI:  n_len = {write_data, sh_llo_q};
							REG_IMASK: begin
								n_imask = write_data;
								if ((write_data & 8'h60 & status_q) != 8'h00 && write_data[7])
									n_status = status_q | 8'h80;
							end
							REG_ADDRCTL: n_addrctl = write_data;
							default: ; // writes to spare registers are ignored
						endcase
					end else if (!active && bus_address == TRIGGER_ADDR && cmd_q[7]) begin
						n_phase = first_phase(cmd_q[1:0]);
					end
				end
				CMD_DMA: begin
					if (active) begin
						case (phase_q)
							PH_STASH, PH_FETCH, PH_SWAP_A, PH_VERIFY: begin
								n_exp = {{(24-RAB){1'b0}}, exp_q[RAB-1:0]}
									+ {23'd0, !addrctl_q[6]};
							end
							default: ;
						endcase
						if (phase_q != PH_SWAP_A && phase_q != PH_VERR && !addrctl_q[7])
							n_host = host_q + 16'd1;
						case (phase_q)
							PH_STASH: begin
								ram_we = 1'b1;
								if (len_q != 16'd1) n_len = len_q - 16'd1;
								else begin fin = 1'b1; fl = 8'h40; end
							end
							PH_FETCH: begin
								ram_re = 1'b1;
								kind_d = K_FETCH;
								dwr_d  = 1'b1;
								if (len_q != 16'd1) n_len = len_q - 16'd1;
								else begin fin = 1'b1; fl = 8'h40; end
							end
							PH_SWAP_A: begin
								ram_re  = 1'b1;
								ram_we  = 1'b1;
								kind_d  = K_SWAP_A;
								n_phase = PH_SWAP_B;
							end
							PH_SWAP_B: begin
								kind_d = K_SWAP_B;
								dwr_d  = 1'b1;
								if (len_q != 16'd1) begin
									n_len   = len_q - 16'd1;
									n_phase = PH_SWAP_A;
								end else begin
									fin = 1'b1;
									fl  = 8'h40;
								end
							end
							PH_VERIFY: begin
								ram_re = 1'b1;
								kind_d = K_VERIFY;
								if (len_q != 16'd1) n_len = len_q - 16'd1;
							end
							default: begin
								ram_re = 1'b1;
								kind_d = K_VERR;
							end
						endcase
					end
				end
				default: ;
			endcase
		end
		// end of transfer: clear execute, optional autoload, raise flags
		if (fin) begin
			if (autoload_q) begin
				n_cmd  = {1'b0, sh_cmd_q[6:0]} | 8'h10;
				n_host = {sh_hhi_q, sh_hlo_q};
				n_exp  = {sh_ehi_q, sh_emid_q, sh_elo_q};
				n_len  = {sh_lhi_q, sh_llo_q};
			end else begin
				n_cmd = {1'b0, n_cmd[6:0]} | 8'h10;
			end
			if ((fl & imask_q & 8'h60) != 8'h00 && imask_q[7])
				fl = fl | 8'h80;
			n_status = n_status | fl;
			n_phase  = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_flag_q <= 1'b1;
			status_q    <= 8'h00;
			cmd_q       <= 8'h10;
			host_q      <= 16'h0000;
			exp_q       <= 24'h000000;
			len_q       <= 16'hffff;
			imask_q     <= 8'h00;
			addrctl_q   <= 8'h00;
			autoload_q  <= 1'b0;
			phase_q     <= PH_IDLE;
			sh_cmd_q    <= 8'h00;
			sh_hlo_q    <= 8'h00;
			sh_hhi_q    <= 8'h00;
			sh_elo_q    <= 8'h00;
			sh_emid_q   <= 8'h00;
			sh_ehi_q    <= 8'h00;
			sh_llo_q    <= 8'hff;
			sh_lhi_q    <= 8'hff;
			v_s1        <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cfg_we)
				size_flag_q <= cfg_wdata;
			status_q   <= n_status;
			cmd_q      <= n_cmd;
			host_q     <= n_host;
			exp_q      <= n_exp;
			len_q      <= n_len;
			imask_q    <= n_imask;
			addrctl_q  <= n_addrctl;
			autoload_q <= n_autoload;
			phase_q    <= n_phase;
			if (accept && command == CMD_WRITE && !active && io2_select) begin
				case (idx)
					REG_COMMAND: sh_cmd_q  <= write_data;
					REG_HOST_LO: sh_hlo_q  <= write_data;
					REG_HOST_HI: sh_hhi_q  <= write_data;
					REG_EXP_LO:  sh_elo_q  <= write_data;
					REG_EXP_MID: sh_emid_q <= write_data;
					REG_EXP_HI:  sh_ehi_q  <= write_data;
					REG_LEN_LO:  sh_llo_q  <= write_data;
					REG_LEN_HI:  sh_lhi_q  <= write_data;
					default: ;
				endcase
			end
			if (accept)
				v_s1 <= 1'b1;
			else if (adv_s1)
				v_s1 <= 1'b0;
			if (adv_s1)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1  <= kind_d;
			rdata_s1 <= rdata_d;
			claim_s1 <= claim_d;
			dwr_s1   <= dwr_d;
			hb_s1    <= host_byte;
			last_s1  <= (len_q == 16'd1);
			daddr_s1 <= (command == CMD_DMA && active) ? host_q : 16'h0000;
		end
	end

	// expansion RAM: read-first, one write and one read port on one address
	always_ff @(posedge clk) begin
		if (ram_we)
			mem[ram_addr] <= host_byte;
		if (ram_re)
			ram_rd_q <= mem[ram_addr];
	end

	// swap byte captured when the read of the first swap cycle returns
	always_ff @(posedge clk) begin
		if (adv_s1 && kind_s1 == K_SWAP_A)
			swap_q <= ram_rd_q;
	end

	// output register
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_data    <= rdata_s1;
			read_claimed <= claim_s1;
			dma_address  <= daddr_s1;
			dma_write    <= dwr_s1;
			irq_active   <= s2_apply ? n_status[7] : status_q[7];
			dma_hold     <= s2_apply ? (n_phase != PH_IDLE) : (phase_q != PH_IDLE);
			case (kind_s1)
				K_FETCH:  dma_write_data <= ram_rd_q;
				K_SWAP_B: dma_write_data <= swap_q;
				default:  dma_write_data <= 8'h00;
			endcase
		end
	end

	`REU_ASSERT_NEVER(a_verify_interlock, clk, arst_n, lock_s1 && accept)
	`REU_ASSERT(a_accept_fills_s1, clk, arst_n, accept |=> v_s1)
	`REU_ASSERT(a_s1_moves_to_out, clk, arst_n, adv_s1 |=> out_valid)
	`REU_ASSERT_NEVER(a_s1_overrun, clk, arst_n, v_s1 && !adv_s1 && accept)
endmodule
